// ===== rtl/core/frae_pkg.sv =====
// Shared widths, operation codes and register indexes of the four-register ALU executor.
`default_nettype none
package frae_pkg;

   localparam int REG_WIDTH_DEFAULT = 16;
   localparam int OUT_WIDTH         = 16;
   localparam int IMM_WIDTH         = 10;
   localparam int OP_WIDTH          = 3;
   localparam int IDX_WIDTH         = 2;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_MOV = 3'd0,
      OP_ADD = 3'd1,
      OP_SUB = 3'd2,
      OP_MUL = 3'd3,
      OP_DIV = 3'd4,
      OP_OR  = 3'd5,
      OP_AND = 3'd6,
      OP_NOT = 3'd7
   } op_type;

   localparam logic [IDX_WIDTH-1:0] REG_A = 2'd0;
   localparam logic [IDX_WIDTH-1:0] REG_B = 2'd1;
   localparam logic [IDX_WIDTH-1:0] REG_C = 2'd2;
   localparam logic [IDX_WIDTH-1:0] REG_D = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/core/frae_if.sv =====
// Valid/ready channel interfaces for instruction items and register-dump items.
`default_nettype none
interface frae_req_if;
   logic                             valid;
   logic                             ready;
   logic [frae_pkg::OP_WIDTH-1:0]    req_type;
   logic [frae_pkg::IDX_WIDTH-1:0]   dest_reg;
   logic                             src_is_imm;
   logic [frae_pkg::IDX_WIDTH-1:0]   src_reg;
   logic [frae_pkg::IMM_WIDTH-1:0]   imm_value;

   modport source (output valid, req_type, dest_reg, src_is_imm, src_reg, imm_value,
                   input ready);
   modport sink   (input valid, req_type, dest_reg, src_is_imm, src_reg, imm_value,
                   output ready);
endinterface

interface frae_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [frae_pkg::OUT_WIDTH-1:0] reg_a_out;
   logic signed [frae_pkg::OUT_WIDTH-1:0] reg_b_out;
   logic signed [frae_pkg::OUT_WIDTH-1:0] reg_c_out;
   logic signed [frae_pkg::OUT_WIDTH-1:0] reg_d_out;
   logic                                 div_zero_flag;

   modport source (output valid, reg_a_out, reg_b_out, reg_c_out, reg_d_out, div_zero_flag,
                   input ready);
   modport sink   (input valid, reg_a_out, reg_b_out, reg_c_out, reg_d_out, div_zero_flag,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/core/four_register_alu_executor.sv =====
// Four-register ALU executor: bit-serial datapath, register file and result register.
//
// Usage: each item on req is one decoded instruction acting on registers A-D
// (REG_WIDTH bits, two's complement). Each item gives exactly one item on rsp
// holding all four registers (low 16 bits, zero-extended when REG_WIDTH < 16)
// and the divide-by-zero flag.
// Timing: the datapath works one bit per cycle. Move, add, subtract and the
// logic ops stream the operands LSB first through shift registers with a
// carry flop; multiply shift-adds one multiplier bit a cycle; divide runs a
// restoring step a cycle on the magnitudes. Every operation runs the serial
// loop over all REG_WIDTH bits and then a write-back state that loads the
// result register; a new item is taken only after that write-back.
// req.ready is high only when the datapath is idle.
// Stall: if rsp is not taken, the finished result waits in the output
// register; the next item may be accepted and computed, and its write-back
// holds until the output register is free.
// Reset: synchronous, clears registers A-D to zero and drops rsp.valid.
`default_nettype none
module four_register_alu_executor #(
   parameter int REG_WIDTH = frae_pkg::REG_WIDTH_DEFAULT
) (
   input  wire           clock,
   input  wire           reset,
   frae_req_if.sink      req,
   frae_rsp_if.source    rsp
);

   localparam int W   = REG_WIDTH;
   localparam int CW  = $clog2(REG_WIDTH);
   localparam int OW  = frae_pkg::OUT_WIDTH;
   localparam int IW  = frae_pkg::IMM_WIDTH;
   localparam logic [W-1:0]  ONE      = W'(1);
   localparam logic [CW-1:0] CNT_LAST = CW'(REG_WIDTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   function automatic logic [W-1:0] sel_reg(input logic [frae_pkg::IDX_WIDTH-1:0] idx,
                                            input logic [W-1:0] ra, input logic [W-1:0] rb,
                                            input logic [W-1:0] rc, input logic [W-1:0] rd);
      logic [W-1:0] v;
      unique case (idx)
         frae_pkg::REG_A: v = ra;
         frae_pkg::REG_B: v = rb;
         frae_pkg::REG_C: v = rc;
         default:         v = rd;
      endcase
      return v;
   endfunction

   function automatic logic [W-1:0] neg(input logic [W-1:0] v);
      return (~v) + ONE;
   endfunction

   function automatic logic [OW-1:0] out_bits(input logic [W-1:0] v);
      logic [W+OW-1:0] x;
      x = {{OW{1'b0}}, v};
      return x[OW-1:0];
   endfunction

   state_type              state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   frae_pkg::op_type       op_ff, op_in;
   logic [frae_pkg::IDX_WIDTH-1:0] dst_ff, dst_in;
   logic [W-1:0]           a_sh_ff, a_sh_in;
   logic [W-1:0]           b_sh_ff, b_sh_in;
   logic [W-1:0]           res_ff, res_in;
   logic [W-1:0]           rem_ff, rem_in;
   logic                   carry_ff, carry_in;
   logic                   num_neg_ff, num_neg_in;
   logic                   quo_neg_ff, quo_neg_in;
   logic                   dzero_ff, dzero_in;
   logic [W-1:0]           reg_a_ff, reg_a_in;
   logic [W-1:0]           reg_b_ff, reg_b_in;
   logic [W-1:0]           reg_c_ff, reg_c_in;
   logic [W-1:0]           reg_d_ff, reg_d_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]          out_a_ff, out_a_in;
   logic [OW-1:0]          out_b_ff, out_b_in;
   logic [OW-1:0]          out_c_ff, out_c_in;
   logic [OW-1:0]          out_d_ff, out_d_in;
   logic                   flag_ff, flag_in;

   logic                   req_fire;
   logic                   out_free;
   logic                   rsp_load;
   logic [W+IW-1:0]        imm_ext;
   logic [W-1:0]           dval, sval;
   logic                   a0, b0, bit_r;
   logic [W:0]             rem_sh, diff;
   logic [W-1:0]           wr_val, quo, rmd;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid & req.ready;
   assign out_free  = ~rsp_valid_ff | rsp.ready;
   assign rsp_load  = (state_ff == ST_DONE) & out_free;
   assign imm_ext   = {{W{1'b0}}, req.imm_value};

   always_comb begin
      dval = sel_reg(req.dest_reg, reg_a_ff, reg_b_ff, reg_c_ff, reg_d_ff);
      sval = req.src_is_imm ? imm_ext[W-1:0]
                            : sel_reg(req.src_reg, reg_a_ff, reg_b_ff, reg_c_ff, reg_d_ff);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      dst_in       = dst_ff;
      a_sh_in      = a_sh_ff;
      b_sh_in      = b_sh_ff;
      res_in       = res_ff;
      rem_in       = rem_ff;
      carry_in     = carry_ff;
      num_neg_in   = num_neg_ff;
      quo_neg_in   = quo_neg_ff;
      dzero_in     = dzero_ff;
      reg_a_in     = reg_a_ff;
      reg_b_in     = reg_b_ff;
      reg_c_in     = reg_c_ff;
      reg_d_in     = reg_d_ff;
      out_a_in     = out_a_ff;
      out_b_in     = out_b_ff;
      out_c_in     = out_c_ff;
      out_d_in     = out_d_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      a0           = a_sh_ff[0];
      b0           = b_sh_ff[0];
      bit_r        = 1'b0;
      rem_sh       = {rem_ff, a_sh_ff[W-1]};
      diff         = rem_sh - {1'b0, b_sh_ff};
      quo          = quo_neg_ff ? neg(a_sh_ff) : a_sh_ff;
      rmd          = num_neg_ff ? neg(rem_ff) : rem_ff;
      wr_val       = res_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = frae_pkg::op_type'(req.req_type);
               dst_in   = req.dest_reg;
               cnt_in   = '0;
               res_in   = '0;
               rem_in   = '0;
               carry_in = (frae_pkg::op_type'(req.req_type) == frae_pkg::OP_SUB);
               state_in = ST_RUN;
               if (frae_pkg::op_type'(req.req_type) == frae_pkg::OP_DIV) begin
                  // divide works on magnitudes, signs fixed at write-back
                  a_sh_in    = dval[W-1] ? neg(dval) : dval;
                  b_sh_in    = sval[W-1] ? neg(sval) : sval;
                  num_neg_in = dval[W-1];
                  quo_neg_in = dval[W-1] ^ sval[W-1];
                  dzero_in   = (sval == '0);
               end else begin
                  a_sh_in    = dval;
                  b_sh_in    = sval;
                  num_neg_in = 1'b0;
                  quo_neg_in = 1'b0;
                  dzero_in   = 1'b0;
               end
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DONE;
            end
            unique case (op_ff)
               frae_pkg::OP_MUL: begin
                  if (b0) begin
                     res_in = res_ff + a_sh_ff;
                  end
                  a_sh_in = {a_sh_ff[W-2:0], 1'b0};
                  b_sh_in = {1'b0, b_sh_ff[W-1:1]};
               end
               frae_pkg::OP_DIV: begin
                  // restoring step: keep the difference when it does not borrow
                  if (!diff[W]) begin
                     rem_in = diff[W-1:0];
                  end else begin
                     rem_in = rem_sh[W-1:0];
                  end
                  a_sh_in = {a_sh_ff[W-2:0], ~diff[W]};
               end
               frae_pkg::OP_MOV: bit_r = b0;
               frae_pkg::OP_ADD: begin
                  bit_r    = a0 ^ b0 ^ carry_ff;
                  carry_in = (a0 & b0) | (a0 & carry_ff) | (b0 & carry_ff);
               end
               frae_pkg::OP_SUB: begin
                  bit_r    = a0 ^ ~b0 ^ carry_ff;
                  carry_in = (a0 & ~b0) | (a0 & carry_ff) | (~b0 & carry_ff);
               end
               frae_pkg::OP_OR:  bit_r = a0 | b0;
               frae_pkg::OP_AND: bit_r = a0 & b0;
               frae_pkg::OP_NOT: bit_r = ~a0;
            endcase
            if (op_ff != frae_pkg::OP_MUL && op_ff != frae_pkg::OP_DIV) begin
               a_sh_in = {1'b0, a_sh_ff[W-1:1]};
               b_sh_in = {1'b0, b_sh_ff[W-1:1]};
               res_in  = {bit_r, res_ff[W-1:1]};
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               flag_in = 1'b0;
               if (op_ff == frae_pkg::OP_DIV) begin
                  wr_val = quo;
                  if (!dzero_ff && dst_ff != frae_pkg::REG_D) begin
                     reg_d_in = rmd;
                  end
               end
               if (op_ff == frae_pkg::OP_DIV && dzero_ff) begin
                  flag_in = 1'b1;
               end else begin
                  unique case (dst_ff)
                     frae_pkg::REG_A: reg_a_in = wr_val;
                     frae_pkg::REG_B: reg_b_in = wr_val;
                     frae_pkg::REG_C: reg_c_in = wr_val;
                     default:         reg_d_in = wr_val;
                  endcase
               end
               out_a_in     = out_bits(reg_a_in);
               out_b_in     = out_bits(reg_b_in);
               out_c_in     = out_bits(reg_c_in);
               out_d_in     = out_bits(reg_d_in);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         reg_a_ff     <= '0;
         reg_b_ff     <= '0;
         reg_c_ff     <= '0;
         reg_d_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         reg_a_ff     <= reg_a_in;
         reg_b_ff     <= reg_b_in;
         reg_c_ff     <= reg_c_in;
         reg_d_ff     <= reg_d_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      op_ff      <= op_in;
      dst_ff     <= dst_in;
      a_sh_ff    <= a_sh_in;
      b_sh_ff    <= b_sh_in;
      res_ff     <= res_in;
      rem_ff     <= rem_in;
      carry_ff   <= carry_in;
      num_neg_ff <= num_neg_in;
      quo_neg_ff <= quo_neg_in;
      dzero_ff   <= dzero_in;
      out_a_ff   <= out_a_in;
      out_b_ff   <= out_b_in;
      out_c_ff   <= out_c_in;
      out_d_ff   <= out_d_in;
      flag_ff    <= flag_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.reg_a_out     = out_a_ff;
   assign rsp.reg_b_out     = out_b_ff;
   assign rsp.reg_c_out     = out_c_ff;
   assign rsp.reg_d_out     = out_d_ff;
   assign rsp.div_zero_flag = flag_ff;

`ifndef SYNTH
   a_fire_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_RUN && cnt_ff == '0)
      else $error("accepted item did not start the serial loop");

   a_run_length: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN && cnt_ff != CNT_LAST |=> state_ff == ST_RUN)
      else $error("serial loop left early");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside write-back");

   a_flag_only_div: assert property (@(posedge clock) disable iff (reset)
      rsp_load && flag_in |-> op_ff == frae_pkg::OP_DIV && dzero_ff)
      else $error("divide-by-zero flag on a non-divide");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready)
      else $error("item accepted while busy");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the four-register ALU executor.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;

   typedef struct {
      frae_pkg::op_type                 op;
      logic [frae_pkg::IDX_WIDTH-1:0]   dst;
      logic                             use_imm;
      logic [frae_pkg::IDX_WIDTH-1:0]   sreg;
      logic [frae_pkg::IMM_WIDTH-1:0]   imm;
   } instr_type;

   typedef struct {
      logic signed [frae_pkg::OUT_WIDTH-1:0] a;
      logic signed [frae_pkg::OUT_WIDTH-1:0] b;
      logic signed [frae_pkg::OUT_WIDTH-1:0] c;
      logic signed [frae_pkg::OUT_WIDTH-1:0] d;
      logic                                  dz;
   } reg_dump_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   frae_req_if req_ch ();
   frae_rsp_if rsp_ch ();

   four_register_alu_executor u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #5 clock = ~clock;

   instr_type      instr_queue[$];
   reg_dump_type   expected_dumps[$];
   logic signed [frae_pkg::OUT_WIDTH-1:0] shadow_regs[4];

   int  items_in      = 0;
   int  dumps_checked = 0;
   int  div_zero_seen = 0;
   int  mismatches    = 0;
   int  cycles        = 0;
   int  total_items   = 0;
   logic req_fire     = 1'b0;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  hold_left     = 0;
   bit  hold_done     = 1'b0;

   task automatic report(input string what);
      $display("ERROR at cycle %0d: %s", cycles, what);
      mismatches++;
   endtask

   task automatic add_instr(input frae_pkg::op_type op, input int dst, input bit use_imm,
                            input int sreg, input int imm);
      instr_type it;
      it.op      = op;
      it.dst     = dst[frae_pkg::IDX_WIDTH-1:0];
      it.use_imm = use_imm;
      it.sreg    = sreg[frae_pkg::IDX_WIDTH-1:0];
      it.imm     = imm[frae_pkg::IMM_WIDTH-1:0];
      instr_queue.push_back(it);
   endtask

   // Execute one instruction on the shadow registers and return the dump it gives.
   function automatic reg_dump_type execute_instr(input instr_type it);
      reg_dump_type res;
      logic [15:0]  src;
      logic [15:0]  dval;
      int           num;
      int           den;
      int           quo;
      int           rem;
      src  = it.use_imm ? {6'd0, it.imm} : shadow_regs[it.sreg];
      dval = shadow_regs[it.dst];
      res.dz = 1'b0;
      case (it.op)
         frae_pkg::OP_MOV: dval = src;
         frae_pkg::OP_ADD: dval = dval + src;
         frae_pkg::OP_SUB: dval = dval - src;
         frae_pkg::OP_MUL: dval = dval * src;
         frae_pkg::OP_DIV: begin
            num = $signed(dval);
            den = $signed(src);
            if (den == 0) begin
               res.dz = 1'b1;
            end else begin
               quo = num / den;
               rem = num % den;
               if (it.dst != frae_pkg::REG_D) shadow_regs[frae_pkg::REG_D] = rem[15:0];
               dval = quo[15:0];
            end
         end
         frae_pkg::OP_OR:  dval = dval | src;
         frae_pkg::OP_AND: dval = dval & src;
         default: dval = ~dval;
      endcase
      shadow_regs[it.dst] = dval;
      res.a = shadow_regs[frae_pkg::REG_A];
      res.b = shadow_regs[frae_pkg::REG_B];
      res.c = shadow_regs[frae_pkg::REG_C];
      res.d = shadow_regs[frae_pkg::REG_D];
      return res;
   endfunction

   // Idle rates per phase, keyed on how many items have gone in.
   always_comb begin
      if (items_in < total_items / 3) begin
         send_idle_pct = 20;
         recv_idle_pct = 52;
      end else if (items_in < (2 * total_items) / 3) begin
         send_idle_pct = 52;
         recv_idle_pct = 20;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   // Sample acceptance and predict the dump of each accepted item.
   always @(posedge clock) begin
      instr_type it;
      if (reset) begin
         req_fire <= 1'b0;
         for (int k = 0; k < 4; k++) shadow_regs[k] = '0;
      end else begin
         req_fire <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            it.op      = frae_pkg::op_type'(req_ch.req_type);
            it.dst     = req_ch.dest_reg;
            it.use_imm = req_ch.src_is_imm;
            it.sreg    = req_ch.src_reg;
            it.imm     = req_ch.imm_value;
            expected_dumps.push_back(execute_instr(it));
            items_in <= items_in + 1;
         end
      end
   end

   // Driver: load the next pending item once the current one has gone.
   always @(negedge clock) begin
      instr_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (instr_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = instr_queue.pop_front();
            req_ch.req_type   <= nxt.op;
            req_ch.dest_reg   <= nxt.dst;
            req_ch.src_is_imm <= nxt.use_imm;
            req_ch.src_reg    <= nxt.sreg;
            req_ch.imm_value  <= nxt.imm;
            req_ch.valid      <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off late in the run.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!hold_done && items_in >= total_items - 300) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         hold_done    <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: compare each accepted dump with the oldest expectation.
   always @(posedge clock) begin
      reg_dump_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_dumps.size() == 0) begin
            report("register dump with no instruction outstanding");
         end else begin
            want = expected_dumps.pop_front();
            if (rsp_ch.reg_a_out !== want.a)
               report($sformatf("dump %0d reg_a_out %0d, want %0d",
                                dumps_checked, rsp_ch.reg_a_out, want.a));
            if (rsp_ch.reg_b_out !== want.b)
               report($sformatf("dump %0d reg_b_out %0d, want %0d",
                                dumps_checked, rsp_ch.reg_b_out, want.b));
            if (rsp_ch.reg_c_out !== want.c)
               report($sformatf("dump %0d reg_c_out %0d, want %0d",
                                dumps_checked, rsp_ch.reg_c_out, want.c));
            if (rsp_ch.reg_d_out !== want.d)
               report($sformatf("dump %0d reg_d_out %0d, want %0d",
                                dumps_checked, rsp_ch.reg_d_out, want.d));
            if (rsp_ch.div_zero_flag !== want.dz)
               report($sformatf("dump %0d div_zero_flag %b, want %b",
                                dumps_checked, rsp_ch.div_zero_flag, want.dz));
            if (want.dz) div_zero_seen++;
         end
         dumps_checked++;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d dumps still due", cycles,
                  expected_dumps.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int r;
      req_ch.valid      = 1'b0;
      req_ch.req_type   = '0;
      req_ch.dest_reg   = '0;
      req_ch.src_is_imm = 1'b0;
      req_ch.src_reg    = '0;
      req_ch.imm_value  = '0;
      rsp_ch.ready      = 1'b0;

      // Directed: every operation, field extremes, wrap and the divide corners.
      add_instr(frae_pkg::OP_MOV, frae_pkg::REG_A, 1, frae_pkg::REG_D, 999);
      // immediate at the top of its 10-bit field
      add_instr(frae_pkg::OP_MOV, frae_pkg::REG_B, 1, frae_pkg::REG_A, 1023);
      // product wraps
      add_instr(frae_pkg::OP_MUL, frae_pkg::REG_A, 0, frae_pkg::REG_B, 0);
      // source fields ignored
      add_instr(frae_pkg::OP_NOT, frae_pkg::REG_C, 1, frae_pkg::REG_B, 1023);
      add_instr(frae_pkg::OP_OR,  frae_pkg::REG_C, 1, frae_pkg::REG_A, 0);
      add_instr(frae_pkg::OP_AND, frae_pkg::REG_C, 1, frae_pkg::REG_A, 682);
      add_instr(frae_pkg::OP_MOV, frae_pkg::REG_D, 1, frae_pkg::REG_C, 1);
      add_instr(frae_pkg::OP_MUL, frae_pkg::REG_D, 1, frae_pkg::REG_C, 512);
      // reaches the most negative value
      add_instr(frae_pkg::OP_MUL, frae_pkg::REG_D, 1, frae_pkg::REG_C, 64);
      // wraps to the most positive
      add_instr(frae_pkg::OP_SUB, frae_pkg::REG_D, 1, frae_pkg::REG_C, 1);
      // and back again
      add_instr(frae_pkg::OP_ADD, frae_pkg::REG_D, 1, frae_pkg::REG_C, 1);
      add_instr(frae_pkg::OP_MOV, frae_pkg::REG_C, 1, frae_pkg::REG_A, 0);
      // C = -1
      add_instr(frae_pkg::OP_NOT, frae_pkg::REG_C, 0, frae_pkg::REG_D, 0);
      add_instr(frae_pkg::OP_MOV, frae_pkg::REG_A, 0, frae_pkg::REG_D, 0);
      // overflow into D, quotient kept
      add_instr(frae_pkg::OP_DIV, frae_pkg::REG_D, 0, frae_pkg::REG_C, 0);
      // overflow, remainder zero into D
      add_instr(frae_pkg::OP_DIV, frae_pkg::REG_A, 0, frae_pkg::REG_C, 0);
      // zero immediate divisor
      add_instr(frae_pkg::OP_DIV, frae_pkg::REG_B, 1, frae_pkg::REG_C, 0);
      // zero register divisor
      add_instr(frae_pkg::OP_DIV, frae_pkg::REG_B, 0, frae_pkg::REG_D, 0);
      add_instr(frae_pkg::OP_MOV, frae_pkg::REG_A, 1, frae_pkg::REG_B, 7);
      add_instr(frae_pkg::OP_NOT, frae_pkg::REG_A, 0, frae_pkg::REG_A, 512);
      // negative dividend, negative remainder
      add_instr(frae_pkg::OP_DIV, frae_pkg::REG_A, 1, frae_pkg::REG_B, 3);
      add_instr(frae_pkg::OP_DIV, frae_pkg::REG_B, 1, frae_pkg::REG_A, 5);
      // D by register, remainder dropped
      add_instr(frae_pkg::OP_DIV, frae_pkg::REG_D, 0, frae_pkg::REG_B, 0);
      add_instr(frae_pkg::OP_ADD, frae_pkg::REG_C, 0, frae_pkg::REG_C, 0);
      add_instr(frae_pkg::OP_SUB, frae_pkg::REG_A, 0, frae_pkg::REG_A, 0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r = $urandom_range(99);
         add_instr(frae_pkg::op_type'($urandom_range(7)), $urandom_range(3),
                   $urandom_range(1), $urandom_range(3),
                   (r < 65) ? $urandom_range(999) :
                   (r < 80) ? $urandom_range(1023) : $urandom_range(15));
      end
      total_items = instr_queue.size();

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (instr_queue.size() > 0 || req_ch.valid || expected_dumps.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Executed %0d instructions and checked %0d register dumps,", items_in,
               dumps_checked);
      $display("%0d of them divide-by-zero, over three back-pressure phases and one long stall",
               div_zero_seen);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire
